[rtl/gregorian_date_subtract_defines.svh]
// Assertion macros for the Gregorian date subtract checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef GREGORIAN_DATE_SUBTRACT_DEFINES_SVH
`define GREGORIAN_DATE_SUBTRACT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define GDS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define GDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gds_pkg.sv]
// Types, codes and constants for the Gregorian date subtract block.
// No dependencies; used by every other file of the block except the assertion macro header.
package gds_pkg;

  typedef logic [1:0]  cmd_t;
  typedef logic [4:0]  day_t;
  typedef logic [3:0]  month_t;
  typedef logic [13:0] year_t;
  typedef logic [15:0] amount_t;

  typedef enum logic [1:0] {
    CMD_DAYS   = 2'd0,
    CMD_MONTHS = 2'd1,
    CMD_YEARS  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_RUN,
    ST_FINISH
  } st_e;

  // Request into the month length unit
  typedef struct packed {
    year_t  year;
    month_t month;
  } gds_ml_req_t;

  localparam year_t  YEAR_MAX  = 14'd9999;
  localparam month_t MONTH_MIN = 4'd1;
  localparam month_t MONTH_MAX = 4'd12;
  localparam day_t   DAY_MIN   = 5'd1;
  localparam day_t   DAY_MAX   = 5'd31;
  localparam day_t   FEB_LEAP  = 5'd29;
  localparam day_t   FEB_PLAIN = 5'd28;
  localparam month_t MONTH_FEB = 4'd2;

  // Divisibility by 25 through the modular inverse of 25 mod 2^14
  localparam year_t INV25     = 14'd7209;
  localparam year_t DIV25_LIM = 14'd655;

  // Month lengths, February resolved separately
  localparam day_t MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd0, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

endpackage

[rtl/gds_if.sv]
// Valid/ready channel interfaces for the date subtract block.
// Depends on gds_pkg for the payload field types.
interface gds_in_if;
  import gds_pkg::*;

  logic    valid;
  logic    ready;
  cmd_t    cmd;
  day_t    day_in;
  month_t  month_in;
  year_t   year_in;
  amount_t amount;

  modport source (output valid, cmd, day_in, month_in, year_in, amount, input ready);
  modport sink   (input valid, cmd, day_in, month_in, year_in, amount, output ready);
endinterface

interface gds_out_if;
  import gds_pkg::*;

  logic   valid;
  logic   ready;
  day_t   day_out;
  month_t month_out;
  year_t  year_out;
  logic   underflow;

  modport source (output valid, day_out, month_out, year_out, underflow, input ready);
  modport sink   (input valid, day_out, month_out, year_out, underflow, output ready);
endinterface

[rtl/gds_month_len.sv]
// Month length unit: days in a given month of a given year, leap rules included.
// Depends on gds_pkg.
module gds_month_len (
  input  gds_pkg::gds_ml_req_t req_i,
  output gds_pkg::day_t        days_o
);
  import gds_pkg::*;

  logic [27:0] prod;
  year_t       prod_lo;
  logic        div4;
  logic        div16;
  logic        div25;
  logic        leap;
  month_t      idx;

  // Test divisibility by 25 with one multiply and a compare
  assign prod    = req_i.year * INV25;
  assign prod_lo = prod[13:0];
  assign div25   = (prod_lo <= DIV25_LIM);
  assign div4    = (req_i.year[1:0] == 2'b00);
  assign div16   = (req_i.year[3:0] == 4'b0000);
  assign leap    = (div4 && !div25) || (div16 && div25);

  // Fold an out-of-range month into the table
  always_comb begin
    if (req_i.month == 4'd0) begin
      idx = MONTH_MIN;
    end else if (req_i.month > MONTH_MAX) begin
      idx = MONTH_MAX;
    end else begin
      idx = req_i.month;
    end
  end

  // Pick the length
  always_comb begin
    if (idx == MONTH_FEB) begin
      days_o = leap ? FEB_LEAP : FEB_PLAIN;
    end else begin
      days_o = MONTH_LEN[idx];
    end
  end

endmodule

[rtl/gregorian_date_subtract.sv]
// Gregorian date subtract: steps a date back by days, months or years, one step per
// cycle through a shared month length unit. An accepted beat has its fields corrected
// as it is registered, then a setup state does the start-day clamp and underflow
// precheck, then one step per unit of amount (up to 65535) runs, then the result
// loads into the output register once it is free. A subtraction that
// would reach before 1 January of year 0 flags underflow and returns the corrected start
// date. ready stays low from acceptance until the result is loaded; the result waits in
// its register while the next beat is taken.
// Depends on gds_pkg, gds_if and gds_month_len.
module gregorian_date_subtract (
  input  logic clk_i,
  input  logic rst_ni,
  gds_in_if.sink    in_i,
  gds_out_if.source out_o
);
  import gds_pkg::*;

  st_e     st_q, st_d;
  cmd_e    cmd_q, cmd_d;
  amount_t cnt_q, cnt_d;
  day_t    d0_q, d0_d;
  month_t  m0_q, m0_d;
  year_t   y0_q, y0_d;
  day_t    rd_q, rd_d;
  month_t  rm_q, rm_d;
  year_t   ry_q, ry_d;
  logic    uf_q, uf_d;
  logic    ov_q, ov_d;
  day_t    od_q, od_d;
  month_t  om_q, om_d;
  year_t   oy_q, oy_d;
  logic    ouf_q, ouf_d;

  gds_ml_req_t ml_req;
  day_t        ml_days;
  logic [17:0] mon_total;
  month_t      m_fix;
  year_t       y_fix;
  day_t        d_fix;
  month_t      nm;
  year_t       ny;
  day_t        clamp_d;

  gds_month_len u_ml (
    .req_i  (ml_req),
    .days_o (ml_days)
  );

  // Correct the incoming fields
  always_comb begin
    if (in_i.month_in == 4'd0) begin
      m_fix = MONTH_MIN;
    end else if (in_i.month_in > MONTH_MAX) begin
      m_fix = MONTH_MAX;
    end else begin
      m_fix = in_i.month_in;
    end
    y_fix = (in_i.year_in > YEAR_MAX) ? YEAR_MAX : in_i.year_in;
    d_fix = (in_i.day_in == 5'd0) ? DAY_MIN : in_i.day_in;
  end

  // Months available before the start of year 0
  assign mon_total = ({4'b0, y0_q} << 3) + ({4'b0, y0_q} << 2) + {14'b0, m0_q} - 18'd1;

  // Next month and year for a month step
  assign nm = (rm_q == MONTH_MIN) ? MONTH_MAX : (rm_q - 4'd1);
  assign ny = (rm_q == MONTH_MIN) ? (ry_q - 14'd1) : ry_q;

  // Clamp of the running day against the unit's answer
  assign clamp_d = (rd_q > ml_days) ? ml_days : rd_q;

  // Select the month the shared unit looks up this cycle
  always_comb begin
    ml_req = '{year: ry_q, month: rm_q};
    case (st_q)
      ST_INIT: begin
        ml_req = '{year: y0_q, month: m0_q};
      end
      ST_RUN: begin
        case (cmd_q)
          CMD_DAYS:   ml_req = '{year: ry_q, month: rm_q - 4'd1};
          CMD_MONTHS: ml_req = '{year: ny, month: nm};
          CMD_YEARS:  ml_req = '{year: ry_q - 14'd1, month: rm_q};
          default:    ml_req = '{year: ry_q, month: rm_q};
        endcase
      end
      default: begin
        ml_req = '{year: ry_q, month: rm_q};
      end
    endcase
  end

  // Sequencer: next state and datapath
  always_comb begin
    st_d   = st_q;
    cmd_d  = cmd_q;
    cnt_d  = cnt_q;
    d0_d   = d0_q;
    m0_d   = m0_q;
    y0_d   = y0_q;
    rd_d   = rd_q;
    rm_d   = rm_q;
    ry_d   = ry_q;
    uf_d   = uf_q;
    ov_d   = ov_q;
    od_d   = od_q;
    om_d   = om_q;
    oy_d   = oy_q;
    ouf_d  = ouf_q;

    // Drop the result once taken
    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d = cmd_e'(in_i.cmd);
          cnt_d = in_i.amount;
          d0_d  = d_fix;
          m0_d  = m_fix;
          y0_d  = y_fix;
          st_d  = ST_INIT;
        end
      end

      ST_INIT: begin
        d0_d   = (d0_q > ml_days) ? ml_days : d0_q;
        rd_d   = d0_d;
        rm_d   = m0_q;
        ry_d   = y0_q;
        uf_d   = 1'b0;
        case (cmd_q)
          CMD_MONTHS: uf_d = ({2'b0, cnt_q} > mon_total);
          CMD_YEARS:  uf_d = (cnt_q > {2'b0, y0_q});
          default:    uf_d = 1'b0;
        endcase
        if (cmd_q == CMD_NONE || cnt_q == 16'd0 || uf_d) begin
          st_d = ST_FINISH;
        end else begin
          st_d = ST_RUN;
        end
      end

      ST_RUN: begin
        cnt_d = cnt_q - 16'd1;
        if (cnt_q == 16'd1) begin
          st_d = ST_FINISH;
        end
        case (cmd_q)
          CMD_DAYS: begin
            if (rd_q > DAY_MIN) begin
              rd_d = rd_q - 5'd1;
            end else if (rm_q > MONTH_MIN) begin
              rm_d = rm_q - 4'd1;
              rd_d = ml_days;
            end else if (ry_q != 14'd0) begin
              ry_d = ry_q - 14'd1;
              rm_d = MONTH_MAX;
              rd_d = DAY_MAX;
            end else begin
              uf_d = 1'b1;
              st_d = ST_FINISH;
            end
          end
          CMD_MONTHS: begin
            rm_d   = nm;
            ry_d   = ny;
            rd_d   = clamp_d;
          end
          CMD_YEARS: begin
            ry_d   = ry_q - 14'd1;
            rd_d   = clamp_d;
          end
          default: begin
            st_d = ST_FINISH;
          end
        endcase
      end

      ST_FINISH: begin
        // Load the output register once it is free
        if (!ov_q || out_o.ready) begin
          od_d  = uf_q ? d0_q : rd_q;
          om_d  = uf_q ? m0_q : rm_q;
          oy_d  = uf_q ? y0_q : ry_q;
          ouf_d = uf_q;
          ov_d  = 1'b1;
          st_d  = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cnt_q <= cnt_d;
    d0_q  <= d0_d;
    m0_q  <= m0_d;
    y0_q  <= y0_d;
    rd_q  <= rd_d;
    rm_q  <= rm_d;
    ry_q  <= ry_d;
    uf_q  <= uf_d;
    od_q  <= od_d;
    om_q  <= om_d;
    oy_q  <= oy_d;
    ouf_q <= ouf_d;
  end

  assign in_i.ready      = (st_q == ST_IDLE);
  assign out_o.valid     = ov_q;
  assign out_o.day_out   = od_q;
  assign out_o.month_out = om_q;
  assign out_o.year_out  = oy_q;
  assign out_o.underflow = ouf_q;

endmodule

[rtl/gds_checker.sv]
// Port-level checker for the date subtract block, bound to the top level.
// Depends on gds_pkg and the macros in gregorian_date_subtract_defines.svh.
`include "gregorian_date_subtract_defines.svh"

module gds_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input gds_pkg::day_t   day_out_i,
  input gds_pkg::month_t month_out_i,
  input gds_pkg::year_t  year_out_i
);
  import gds_pkg::*;

  // Hold a stalled result
  `GDS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(year_out_i), "result dropped or changed while stalled")

  // Go busy after taking a beat
  `GDS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "ready stayed high after a beat was taken")

  // No result appears in the cycle right after a beat is taken
  `GDS_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_i, !$rose(out_valid_i), "result appeared during setup")

  // Result month always lies in 1..12, day is at least 1 and year at most 9999
  `GDS_ASSERT_IMPL(a_date_range, out_valid_i, (month_out_i >= MONTH_MIN) && (month_out_i <= MONTH_MAX) && (day_out_i >= DAY_MIN) && (year_out_i <= YEAR_MAX), "result date out of range")

endmodule

bind gregorian_date_subtract gds_checker u_gds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .day_out_i   (out_o.day_out),
  .month_out_i (out_o.month_out),
  .year_out_i  (out_o.year_out)
);

[dv/gregorian_date_subtract_test.sv]
// Self-checking testbench for gregorian_date_subtract: directed and random date beats
// with random idling on both channels, checked against a built-in date predictor.
// Depends on gds_pkg, gds_if and the gregorian_date_subtract RTL.
module gregorian_date_subtract_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gds_pkg::*;

  // One expected result beat
  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
    logic   underflow;
  } date_result_t;

  localparam int STALL_LIMIT = 200_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  gds_in_if  date_in ();
  gds_out_if date_out ();

  gregorian_date_subtract dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (date_in),
    .out_o  (date_out)
  );

  date_result_t pending_dates[$];
  int unsigned  mismatch_count = 0;
  bit           src_idle_on    = 1'b1;
  bit           sink_idle_on   = 1'b1;
  int           sink_hold      = 0;

  always #1 clk_i = ~clk_i;

  // Number of days in a month, leap years included (year 0 is leap)
  function automatic int month_days(int yr, int mo);
    if (mo == MONTH_FEB) begin
      return (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) ? FEB_LEAP : FEB_PLAIN;
    end
    return MONTH_LEN[mo];
  endfunction

  // Predict the date that results from one request beat
  function automatic date_result_t subtract_date(cmd_t c, day_t d_i, month_t m_i,
                                                 year_t y_i, amount_t a);
    int d, m, y, rd, rm, ry, lim, n;
    bit uf;
    date_result_t r;
    // Correct out-of-range start fields, month and year first
    m = m_i;
    if (m < MONTH_MIN) m = MONTH_MIN;
    if (m > MONTH_MAX) m = MONTH_MAX;
    y = y_i;
    if (y > YEAR_MAX) y = YEAR_MAX;
    d = d_i;
    if (d < DAY_MIN) d = DAY_MIN;
    lim = month_days(y, m);
    if (d > lim) d = lim;
    rd = d;
    rm = m;
    ry = y;
    uf = 1'b0;
    n  = a;
    case (cmd_e'(c))
      CMD_DAYS: begin
        // Step back one day at a time, stop at 1 January of year 0
        while (n > 0 && !uf) begin
          if (rd > 1) begin
            rd--;
          end else if (rm > 1) begin
            rm--;
            rd = month_days(ry, rm);
          end else if (ry > 0) begin
            ry--;
            rm = MONTH_MAX;
            rd = DAY_MAX;
          end else begin
            uf = 1'b1;
          end
          n--;
        end
      end
      CMD_MONTHS: begin
        if (n > ry * 12 + (rm - 1)) begin
          uf = 1'b1;
        end else begin
          // Clamp after every step so a short month sticks
          repeat (n) begin
            if (rm == 1) begin
              rm = MONTH_MAX;
              ry--;
            end else begin
              rm--;
            end
            lim = month_days(ry, rm);
            if (rd > lim) rd = lim;
          end
        end
      end
      CMD_YEARS: begin
        if (n > ry) begin
          uf = 1'b1;
        end else begin
          repeat (n) begin
            ry--;
            lim = month_days(ry, rm);
            if (rd > lim) rd = lim;
          end
        end
      end
      default: ;
    endcase
    // Return the corrected start date on underflow
    if (uf) begin
      rd = d;
      rm = m;
      ry = y;
    end
    r.day       = day_t'(rd);
    r.month     = month_t'(rm);
    r.year      = year_t'(ry);
    r.underflow = uf;
    return r;
  endfunction

  // Offer one request beat, hold it until accepted, queue its prediction
  task automatic send_date(input cmd_t c, input day_t d, input month_t m, input year_t y,
                           input amount_t a);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      date_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    date_in.valid    <= 1'b1;
    date_in.cmd      <= c;
    date_in.day_in   <= d;
    date_in.month_in <= m;
    date_in.year_in  <= y;
    date_in.amount   <= a;
    do @(posedge clk_i); while (!date_in.ready);
    pending_dates.push_back(subtract_date(c, d, m, y, a));
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_dates();
    date_in.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  // Day steps across month, leap February, century and year 0 boundaries
  task automatic test_days();
    send_date(CMD_DAYS, 5'd1, 4'd3, 14'd2024, 16'd1);
    send_date(CMD_DAYS, 5'd1, 4'd3, 14'd1900, 16'd1);
    send_date(CMD_DAYS, 5'd1, 4'd3, 14'd2000, 16'd1);
    send_date(CMD_DAYS, 5'd1, 4'd1, 14'd0, 16'd1);
    send_date(CMD_DAYS, 5'd31, 4'd12, 14'd0, 16'd365);
    send_date(CMD_DAYS, 5'd31, 4'd12, 14'd0, 16'd366);
    send_date(CMD_DAYS, 5'd15, 4'd6, 14'd2023, 16'd0);
    send_date(CMD_DAYS, 5'd31, 4'd12, 14'd9999, 16'hFFFF);
  endtask

  // Month steps with a sticky clamp and the exact year 0 limit
  task automatic test_months();
    send_date(CMD_MONTHS, 5'd31, 4'd3, 14'd2023, 16'd1);
    send_date(CMD_MONTHS, 5'd31, 4'd3, 14'd2024, 16'd2);
    send_date(CMD_MONTHS, 5'd1, 4'd1, 14'd0, 16'd1);
    send_date(CMD_MONTHS, 5'd31, 4'd12, 14'd0, 16'd11);
    send_date(CMD_MONTHS, 5'd31, 4'd5, 14'd9999, 16'hFFFF);
  endtask

  // Year steps from a leap day, and year underflow
  task automatic test_years();
    send_date(CMD_YEARS, 5'd29, 4'd2, 14'd2024, 16'd1);
    send_date(CMD_YEARS, 5'd29, 4'd2, 14'd2024, 16'd4);
    send_date(CMD_YEARS, 5'd5, 4'd5, 14'd10, 16'd11);
    send_date(CMD_YEARS, 5'd5, 4'd5, 14'd10, 16'd10);
    send_date(CMD_YEARS, 5'd1, 4'd1, 14'd9999, 16'hFFFF);
  endtask

  // Out-of-range start fields and the unknown command
  task automatic test_corrections();
    send_date(CMD_NONE, 5'd0, 4'd0, 14'h3FFF, 16'd0);
    send_date(CMD_DAYS, 5'd31, 4'd15, 14'd9998, 16'd5);
    send_date(CMD_MONTHS, 5'd31, 4'd4, 14'd2023, 16'd1);
    send_date(CMD_YEARS, 5'd31, 4'd2, 14'd2100, 16'd1);
    send_date(CMD_NONE, 5'd31, 4'd13, 14'd12345, 16'hFFFF);
  endtask

  // Hold the result side off long enough to stall the input, then pause the sender
  task automatic test_backpressure();
    drain_dates();
    sink_hold = 300;
    repeat (6) begin
      send_date(cmd_t'($urandom_range(0, 2)), day_t'($urandom_range(1, 28)),
                month_t'($urandom_range(1, 12)), year_t'($urandom_range(0, 9999)),
                amount_t'($urandom_range(0, 40)));
    end
    drain_dates();
  endtask

  // Mostly legal dates with random content, some raw noise, a few huge amounts
  task automatic test_random(input int count, input bit idle_phases);
    int kind, lim, yr, mo;
    cmd_t c;
    day_t d;
    amount_t a;
    for (int i = 0; i < count; i++) begin
      // Alternate stretches with and without idling
      src_idle_on  = idle_phases && ((i / 16) % 2 == 0);
      sink_idle_on = idle_phases && ((i / 12) % 2 == 0);
      kind = $urandom_range(0, 99);
      if (idle_phases && i % 20 == 7) begin
        // Full 16-bit amount, long run
        send_date(cmd_t'($urandom), day_t'($urandom), month_t'($urandom),
                  year_t'($urandom), amount_t'($urandom));
      end else if (kind < 82) begin
        c   = cmd_t'($urandom_range(0, 2));
        yr  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 9999);
        mo  = $urandom_range(1, 12);
        lim = month_days(yr, mo);
        d   = ($urandom_range(0, 2) == 0) ? day_t'(lim - $urandom_range(0, 2))
                                          : day_t'($urandom_range(1, lim));
        case (cmd_e'(c))
          CMD_DAYS:   a = amount_t'($urandom_range(0, 1500));
          CMD_MONTHS: a = amount_t'($urandom_range(0, 150));
          default:    a = amount_t'($urandom_range(0, (yr < 40) ? yr + 3 : 600));
        endcase
        send_date(c, d, month_t'(mo), year_t'(yr), a);
      end else begin
        send_date(cmd_t'($urandom), day_t'($urandom), month_t'($urandom),
                  year_t'($urandom), amount_t'($urandom_range(0, 2047)));
      end
    end
  endtask

  // Drive, reset and run the tests in turn
  initial begin
    date_in.valid    <= 1'b0;
    date_in.cmd      <= CMD_NONE;
    date_in.day_in   <= DAY_MIN;
    date_in.month_in <= MONTH_MIN;
    date_in.year_in  <= '0;
    date_in.amount   <= '0;
    rst_ni           <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_days();
    test_months();
    test_years();
    test_corrections();
    test_backpressure();
    test_random(70, 1'b1);
    test_random(12, 1'b0);
    drain_dates();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side ready: a long hold-off when a test asks for one, else random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    date_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        date_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        date_out.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        date_out.ready <= 1'b0;
      end else begin
        date_out.ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni && date_out.valid && date_out.ready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result beat: day %0d month %0d year %0d underflow %0b",
               date_out.day_out, date_out.month_out, date_out.year_out, date_out.underflow);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        if (date_out.day_out !== want.day) begin
          $error("day_out: expected %0d, got %0d", want.day, date_out.day_out);
          mismatch_count++;
        end
        if (date_out.month_out !== want.month) begin
          $error("month_out: expected %0d, got %0d", want.month, date_out.month_out);
          mismatch_count++;
        end
        if (date_out.year_out !== want.year) begin
          $error("year_out: expected %0d, got %0d", want.year, date_out.year_out);
          mismatch_count++;
        end
        if (date_out.underflow !== want.underflow) begin
          $error("underflow: expected %0b, got %0b", want.underflow, date_out.underflow);
          mismatch_count++;
        end
      end
    end
  end

  // End the run when no beat moves on either side for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((date_in.valid && date_in.ready) || (date_out.valid && date_out.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no beat accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_dates.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
